@@ src/slu_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the string literal unescaper.
// No dependencies.
package slu_pkg;

    localparam int CNT_W = 16;
    localparam int OUT_W = 16;
    localparam int CAP_W = 16;
    localparam int CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

    typedef enum logic [2:0] {
        M_OPEN,
        M_BODY,
        M_BSL,
        M_HEX1,
        M_HEX2,
        M_UBRACE,
        M_UDIG,
        M_SKIP
    } t_mode;

    typedef enum logic [1:0] {
        K_BYTE  = 2'd0,
        K_DONE  = 2'd1,
        K_ERROR = 2'd2
    } t_kind;

    localparam logic [1:0] K_UNUSED = 2'd3;

    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_SHORT   = 3'd0;
    localparam logic [2:0] E_FULL    = 3'd1;
    localparam logic [2:0] E_ESCAPE  = 3'd2;
    localparam logic [2:0] E_RANGE   = 3'd3;
    localparam logic [2:0] E_SURR    = 3'd4;

    localparam logic [CAP_W-1:0] CAP_RESET = '1;

    typedef struct packed {
        t_mode              mode;
        logic [3:0]         hex_high;
        logic [31:0]        acc;
        logic               digit_seen;
        logic [CNT_W-1:0]   out_count;
        logic [CNT_W-1:0]   byte_index;
        logic [CNT_W-1:0]   escape_start;
    } t_state;

    typedef struct packed {
        logic [2:0]         cnt;
        logic [3:0][7:0]    bytes;
        logic [1:0]         kind;
        logic [2:0]         code;
        logic [OUT_W-1:0]   len;
        logic [OUT_W-1:0]   pos;
        logic               fin;
    } t_pkt;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

@@ src/slu_dec.sv @@
`timescale 1ns / 1ps
// Next-state and result-packet logic for one raw byte of a literal.
// Depends on slu_pkg.
module slu_dec (
    input  slu_pkg::t_state                i_state,
    input  logic [7:0]                     i_raw_byte,
    input  logic                           i_is_last,
    input  logic [slu_pkg::CAP_W-1:0]      i_capacity,
    output slu_pkg::t_state                o_next,
    output slu_pkg::t_pkt                  o_pkt
);
    import slu_pkg::*;

    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_LBR   = 8'h7B;
    localparam logic [7:0] CH_RBR   = 8'h7D;

    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W:0]   idx_p1;
    logic [4:0]       hd;
    logic             full;
    logic [31:0]      cp;
    logic [2:0]       nb;
    logic             fits;
    logic [3:0][7:0]  utf;

    function automatic t_pkt err_pkt(input logic [2:0] code, input logic [OUT_W-1:0] pos);
        t_pkt p;
        p      = '0;
        p.cnt  = 3'd1;
        p.kind = K_ERROR;
        p.code = code;
        p.pos  = pos;
        p.fin  = 1'b1;
        return p;
    endfunction

    function automatic t_pkt byte_pkt(input logic [7:0] b);
        t_pkt p;
        p          = '0;
        p.cnt      = 3'd1;
        p.kind     = K_BYTE;
        p.bytes[0] = b;
        return p;
    endfunction

    always_comb begin
        idx    = (i_state.mode == M_OPEN) ? '0 : i_state.byte_index;
        cnt    = (i_state.mode == M_OPEN) ? '0 : i_state.out_count;
        idx_p1 = {1'b0, idx} + (CNT_W+1)'(1);
        hd     = hex_digit(i_raw_byte);
        full   = CMP_W'(cnt) >= CMP_W'(i_capacity);
        cp     = i_state.acc;

        if (cp <= 32'h7F) begin
            nb = 3'd1;
        end else if (cp <= 32'h7FF) begin
            nb = 3'd2;
        end else if (cp <= 32'hFFFF) begin
            nb = 3'd3;
        end else begin
            nb = 3'd4;
        end
        fits = (CMP_W'(cnt) + CMP_W'(nb)) <= CMP_W'(i_capacity);

        utf = '0;
        case (nb)
            3'd1: begin
                utf[0] = cp[7:0];
            end
            3'd2: begin
                utf[0] = 8'hC0 | {3'b000, cp[10:6]};
                utf[1] = 8'h80 | {2'b00, cp[5:0]};
            end
            3'd3: begin
                utf[0] = 8'hE0 | {4'b0000, cp[15:12]};
                utf[1] = 8'h80 | {2'b00, cp[11:6]};
                utf[2] = 8'h80 | {2'b00, cp[5:0]};
            end
            default: begin
                utf[0] = 8'hF0 | {5'b00000, cp[20:18]};
                utf[1] = 8'h80 | {2'b00, cp[17:12]};
                utf[2] = 8'h80 | {2'b00, cp[11:6]};
                utf[3] = 8'h80 | {2'b00, cp[5:0]};
            end
        endcase

        o_next            = i_state;
        o_next.byte_index = CNT_W'(idx_p1);
        o_next.out_count  = cnt;
        o_pkt             = '0;

        case (i_state.mode)
            M_OPEN: begin
                if (i_is_last) begin
                    o_pkt       = err_pkt(E_SHORT, '0);
                    o_next.mode = M_OPEN;
                end else begin
                    o_next.mode = M_BODY;
                end
            end
            M_SKIP: begin
                if (i_is_last) begin
                    o_next.mode = M_OPEN;
                end
            end
            default: begin
                if (i_is_last) begin
                    o_next.mode = M_OPEN;
                    if (i_state.mode == M_BODY) begin
                        o_pkt      = '0;
                        o_pkt.cnt  = 3'd1;
                        o_pkt.kind = K_DONE;
                        o_pkt.len  = OUT_W'(cnt);
                        o_pkt.fin  = 1'b1;
                    end else begin
                        o_pkt = err_pkt(E_ESCAPE, OUT_W'(i_state.escape_start));
                    end
                end else begin
                    case (i_state.mode)
                        M_BODY: begin
                            if (i_raw_byte == CH_BSL) begin
                                o_next.escape_start = idx;
                                o_next.mode         = M_BSL;
                            end else if (full) begin
                                o_pkt       = err_pkt(E_FULL, '0);
                                o_next.mode = M_SKIP;
                            end else begin
                                o_pkt            = byte_pkt(i_raw_byte);
                                o_next.out_count = cnt + CNT_W'(1);
                            end
                        end
                        M_BSL: begin
                            if (full) begin
                                o_pkt       = err_pkt(E_FULL, '0);
                                o_next.mode = M_SKIP;
                            end else begin
                                o_next.mode = M_BODY;
                                case (i_raw_byte)
                                    CH_N: begin
                                        o_pkt            = byte_pkt(8'h0A);
                                        o_next.out_count = cnt + CNT_W'(1);
                                    end
                                    CH_T: begin
                                        o_pkt            = byte_pkt(8'h09);
                                        o_next.out_count = cnt + CNT_W'(1);
                                    end
                                    CH_R: begin
                                        o_pkt            = byte_pkt(8'h0D);
                                        o_next.out_count = cnt + CNT_W'(1);
                                    end
                                    CH_BSL: begin
                                        o_pkt            = byte_pkt(CH_BSL);
                                        o_next.out_count = cnt + CNT_W'(1);
                                    end
                                    CH_QUOTE: begin
                                        o_pkt            = byte_pkt(CH_QUOTE);
                                        o_next.out_count = cnt + CNT_W'(1);
                                    end
                                    CH_X: begin
                                        o_next.mode = M_HEX1;
                                    end
                                    CH_U: begin
                                        o_next.mode = M_UBRACE;
                                    end
                                    default: begin
                                        o_pkt = err_pkt(E_ESCAPE,
                                                        OUT_W'(i_state.escape_start));
                                        o_next.mode = M_SKIP;
                                    end
                                endcase
                            end
                        end
                        M_HEX1: begin
                            if (!hd[4]) begin
                                o_pkt       = err_pkt(E_ESCAPE, OUT_W'(i_state.escape_start));
                                o_next.mode = M_SKIP;
                            end else begin
                                o_next.hex_high = hd[3:0];
                                o_next.mode     = M_HEX2;
                            end
                        end
                        M_HEX2: begin
                            if (!hd[4]) begin
                                o_pkt       = err_pkt(E_ESCAPE, OUT_W'(i_state.escape_start));
                                o_next.mode = M_SKIP;
                            end else begin
                                o_pkt            = byte_pkt({i_state.hex_high, hd[3:0]});
                                o_next.out_count = cnt + CNT_W'(1);
                                o_next.mode      = M_BODY;
                            end
                        end
                        M_UBRACE: begin
                            if (i_raw_byte != CH_LBR) begin
                                o_pkt       = err_pkt(E_ESCAPE, OUT_W'(i_state.escape_start));
                                o_next.mode = M_SKIP;
                            end else begin
                                o_next.acc        = '0;
                                o_next.digit_seen = 1'b0;
                                o_next.mode       = M_UDIG;
                            end
                        end
                        default: begin
                            if (i_raw_byte != CH_RBR) begin
                                if (!hd[4]) begin
                                    o_pkt       = err_pkt(E_ESCAPE, OUT_W'(idx));
                                    o_next.mode = M_SKIP;
                                end else begin
                                    o_next.acc        = {i_state.acc[27:0], hd[3:0]};
                                    o_next.digit_seen = 1'b1;
                                end
                            end else if (!i_state.digit_seen) begin
                                o_pkt       = err_pkt(E_ESCAPE, OUT_W'(i_state.escape_start));
                                o_next.mode = M_SKIP;
                            end else if (cp > 32'h0010_FFFF) begin
                                o_pkt       = err_pkt(E_RANGE, OUT_W'(idx_p1));
                                o_next.mode = M_SKIP;
                            end else if (cp >= 32'hD800 && cp <= 32'hDFFF) begin
                                o_pkt       = err_pkt(E_SURR, OUT_W'(idx_p1));
                                o_next.mode = M_SKIP;
                            end else if (!fits) begin
                                o_pkt       = err_pkt(E_FULL, '0);
                                o_next.mode = M_SKIP;
                            end else begin
                                o_pkt            = '0;
                                o_pkt.cnt        = nb;
                                o_pkt.kind       = K_BYTE;
                                o_pkt.bytes      = utf;
                                o_next.out_count = cnt + CNT_W'(nb);
                                o_next.mode      = M_BODY;
                            end
                        end
                    endcase
                end
            end
        endcase
    end

endmodule

@@ src/string_literal_unescaper.sv @@
`timescale 1ns / 1ps
// A byte's first result word is registered and shown in the cycle after the byte is accepted.
// Throughput: one raw byte per cycle while the output is not stalled and each gives at most
// one word; a \u{} escape gives up to four words, which leave the output register one per cycle while taken.
// Ready is high when the output register is empty or its last word is taken that cycle.
// Reset (synchronous, active low) empties the output and starts a new literal; capacity 65535.
module string_literal_unescaper (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_raw_byte,
    input  logic                          i_is_last,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_kind,
    output logic [7:0]                    o_data_byte,
    output logic [2:0]                    o_error_code,
    output logic [slu_pkg::OUT_W-1:0]     o_out_length,
    output logic [slu_pkg::OUT_W-1:0]     o_error_position,
    output logic                          o_final_flag,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [slu_pkg::CAP_W-1:0]     i_cfg_data
);
    import slu_pkg::*;

    t_state            r_state;
    t_state            n_state;
    t_pkt              r_pkt;
    t_pkt              n_pkt;
    t_pkt              dec_pkt;
    logic [CAP_W-1:0]  r_cap;
    logic              in_take;
    logic              out_take;

    slu_dec u_dec (
        .i_state    (r_state),
        .i_raw_byte (i_raw_byte),
        .i_is_last  (i_is_last),
        .i_capacity (r_cap),
        .o_next     (n_state),
        .o_pkt      (dec_pkt)
    );

    assign o_out_valid = (r_pkt.cnt != 3'd0);
    assign out_take    = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_pkt.cnt == 3'd0) || ((r_pkt.cnt == 3'd1) && i_out_ready);
    assign in_take     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_pkt = r_pkt;
        if (in_take) begin
            n_pkt = dec_pkt;
        end else if (out_take) begin
            n_pkt.cnt   = r_pkt.cnt - 3'd1;
            n_pkt.bytes = {8'h00, r_pkt.bytes[3:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_pkt.bytes <= n_pkt.bytes;
        r_pkt.kind  <= n_pkt.kind;
        r_pkt.code  <= n_pkt.code;
        r_pkt.len   <= n_pkt.len;
        r_pkt.pos   <= n_pkt.pos;
        r_pkt.fin   <= n_pkt.fin;
        if (!i_rst_n) begin
            r_state.mode         <= M_OPEN;
            r_state.hex_high     <= '0;
            r_state.acc          <= '0;
            r_state.digit_seen   <= 1'b0;
            r_state.out_count    <= '0;
            r_state.byte_index   <= '0;
            r_state.escape_start <= '0;
            r_pkt.cnt            <= '0;
            r_cap                <= CAP_RESET;
        end else begin
            if (in_take) begin
                r_state <= n_state;
            end
            r_pkt.cnt <= n_pkt.cnt;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    assign o_kind           = r_pkt.kind;
    assign o_data_byte      = r_pkt.bytes[0];
    assign o_error_code     = r_pkt.code;
    assign o_out_length     = r_pkt.len;
    assign o_error_position = r_pkt.pos;
    assign o_final_flag     = r_pkt.fin;

endmodule

@@ src/slu_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for string_literal_unescaper, bound to the top level.
// Depends on slu_pkg.
module slu_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic [1:0]                    o_kind,
    input  logic [7:0]                    o_data_byte,
    input  logic [2:0]                    o_error_code,
    input  logic [slu_pkg::OUT_W-1:0]     o_out_length,
    input  logic [slu_pkg::OUT_W-1:0]     o_error_position,
    input  logic                          o_final_flag
);
    import slu_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_kind)
            && $stable(o_data_byte) && $stable(o_final_flag)))
        else $error("output word changed while stalled");

    a_final_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_final_flag == (o_kind != K_BYTE)) && (o_kind != K_UNUSED))
        else $error("final flag does not match kind");

    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == K_BYTE) |->
            (o_error_code == E_NONE && o_out_length == '0 && o_error_position == '0))
        else $error("data word carries status fields");

    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == K_DONE) |->
            (o_error_code == E_NONE && o_error_position == '0 && o_data_byte == 8'h00))
        else $error("done word carries error fields");

    a_error_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == K_ERROR) |->
            (o_out_length == '0 && o_data_byte == 8'h00 && o_error_code <= E_SURR))
        else $error("error word malformed");

endmodule

bind string_literal_unescaper slu_checker u_slu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_kind           (o_kind),
    .o_data_byte      (o_data_byte),
    .o_error_code     (o_error_code),
    .o_out_length     (o_out_length),
    .o_error_position (o_error_position),
    .o_final_flag     (o_final_flag)
);
